// ===== rtl/xcfr_pkg.sv =====
// xcfr_pkg: constants and codes shared by the xor checked frame receiver
// files. Depends on nothing.
package xcfr_pkg;

   localparam int DATA_W      = 8;   // serial byte and payload byte
   localparam int IDX_W       = 6;   // byte_index field
   localparam int STATUS_W    = 2;   // status field
   localparam int LEN_W       = 7;   // payload_length register
   localparam int RSP_TDATA_W = 16;  // data_byte + byte_index, padded to bytes

   localparam logic [DATA_W-1:0] HEADER_BYTE = 8'hAA;
   localparam logic [DATA_W-1:0] FOOTER_BYTE = 8'hBB;
   localparam logic [DATA_W-1:0] ZERO_BYTE   = 8'h00;

   localparam logic [LEN_W-1:0] LEN_RESET = 7'd4;

   localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SUM = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd2;

endpackage

// ===== rtl/xcfr_ram.sv =====
// xcfr_ram: generic single write port, single read port ram with a
// registered read. Depends on nothing.
module xcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/xor_checked_frame_receiver.sv =====
// xor_checked_frame_receiver: top level of the header/footer serial frame
// receiver with xor check byte. Depends on xcfr_pkg and xcfr_ram.
//
// usage
//  - req_*: one received serial byte per transaction (req_tdata = rx_byte)
//  - rsp_*: result transactions; a verified frame gives one transaction per
//    payload byte in order with tlast on the final one, a failed frame gives
//    a single transaction with tlast set and status in tuser
//  - csr_*: payload_length write, taken at any edge with csr_wr_en high; the
//    user must write it only while the block is idle; the block does not enforce this
// sequencing
//  - a byte that produces no result leaves the block ready for the next byte
//  - a footer ending a bad or short frame moves the sequencer to S_ERR, which
//    loads the error result into the output register once that register is free
//  - a footer ending a good frame starts a drain of the payload ram: for each
//    byte a ram read (S_READ), then a load of the output register (S_LOAD); no
//    new byte is taken before the drain ends
//  - the drain pace is set by the registered read of the payload ram
// reset (synchronous) returns to header hunting and payload_length to 4; the
// payload ram has no reset and needs no clearing pass
// when rsp_tready is low the output register holds; bytes that produce no
// result are still accepted, the footer is accepted too, and after it the
// input stalls until its result can be loaded into the output register
module xor_checked_frame_receiver
   import xcfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // [7:0] rx_byte
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [7:0] data_byte, [13:8] byte_index
   output logic [STATUS_W-1:0]    rsp_tuser,   // [1:0] status
   output logic                   rsp_tlast,   // last
   // configuration
   input  logic                   csr_wr_en,
   input  logic [LEN_W-1:0]       csr_wr_data  // payload_length
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;  // ram address
   localparam int CW = $clog2(MAX_PAYLOAD + 1);                      // byte count

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;  // taking serial bytes
   localparam logic [1:0] S_ERR  = 2'd1;  // waiting to emit the error result
   localparam logic [1:0] S_READ = 2'd2;  // issue payload ram read
   localparam logic [1:0] S_LOAD = 2'd3;  // ram data into the output register

   // control state
   logic [1:0]          state_ff, state_in;
   logic [LEN_W-1:0]    length_ff, length_in;
   logic                in_frame_ff, in_frame_in;
   logic [CW-1:0]       byte_count_ff, byte_count_in;
   logic [DATA_W-1:0]   running_xor_ff, running_xor_in;
   logic [DATA_W-1:0]   check_byte_ff, check_byte_in;
   logic                check_seen_ff, check_seen_in;
   logic [AW-1:0]       rd_idx_ff, rd_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [STATUS_W-1:0] err_status_ff, err_status_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   // ram ports
   logic                ram_we;
   logic                ram_re;
   logic [DATA_W-1:0]   ram_rd_data;

   logic [CW-1:0]       eff_len;
   logic                out_free;
   logic                take;
   logic                drain_last;

   // payload_length of zero acts as one, above the store size acts as full
   always_comb begin
      if (length_ff == '0) begin
         eff_len = CW'(1);
      end else if (length_ff > LEN_W'(MAX_PAYLOAD)) begin
         eff_len = CW'(MAX_PAYLOAD);
      end else begin
         eff_len = length_ff[CW-1:0];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign take       = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign drain_last = ((CW'(rd_idx_ff) + CW'(1)) == byte_count_ff);

   // the sequencer keeps ram writes (idle) and ram reads (drain) apart, so
   // no read ever meets a write to the same entry
   always_comb begin
      state_in       = state_ff;
      length_in      = length_ff;
      in_frame_in    = in_frame_ff;
      byte_count_in  = byte_count_ff;
      running_xor_in = running_xor_ff;
      check_byte_in  = check_byte_ff;
      check_seen_in  = check_seen_ff;
      rd_idx_in      = rd_idx_ff;
      err_status_in  = err_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;

      if (csr_wr_en) begin
         length_in = csr_wr_data;
      end

      // result leaves the output register
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (!in_frame_ff) begin
                  // hunting: everything but the header is dropped
                  if (req_tdata == HEADER_BYTE) begin
                     in_frame_in = 1'b1;
                  end
               end else if (req_tdata != FOOTER_BYTE) begin
                  if (byte_count_ff < eff_len) begin
                     ram_we         = 1'b1;
                     running_xor_in = running_xor_ff ^ req_tdata;
                     byte_count_in  = byte_count_ff + CW'(1);
                  end else begin
                     // past the payload: the latest byte is the check byte
                     check_byte_in = req_tdata;
                     check_seen_in = 1'b1;
                  end
               end else begin
                  // footer ends the frame
                  in_frame_in    = 1'b0;
                  running_xor_in = ZERO_BYTE;
                  check_byte_in  = ZERO_BYTE;
                  check_seen_in  = 1'b0;
                  if (!check_seen_ff || byte_count_ff == '0) begin
                     err_status_in = ST_SHORT;
                     byte_count_in = '0;
                     state_in      = S_ERR;
                  end else if (running_xor_ff != check_byte_ff) begin
                     err_status_in = ST_BAD_SUM;
                     byte_count_in = '0;
                     state_in      = S_ERR;
                  end else begin
                     // good frame: byte count kept until the drain ends
                     rd_idx_in = '0;
                     state_in  = S_READ;
                  end
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = ZERO_BYTE;
               rsp_idx_in    = '0;
               rsp_status_in = err_status_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_READ: begin
            // read only when the output register is free on the next cycle
            if (out_free) begin
               ram_re   = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = ram_rd_data;
            rsp_idx_in    = IDX_W'(rd_idx_ff);
            rsp_status_in = ST_GOOD;
            rsp_last_in   = drain_last;
            if (drain_last) begin
               byte_count_in = '0;
               state_in      = S_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff + AW'(1);
               state_in  = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         length_ff      <= LEN_RESET;
         in_frame_ff    <= 1'b0;
         byte_count_ff  <= '0;
         running_xor_ff <= ZERO_BYTE;
         check_byte_ff  <= ZERO_BYTE;
         check_seen_ff  <= 1'b0;
         rd_idx_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         length_ff      <= length_in;
         in_frame_ff    <= in_frame_in;
         byte_count_ff  <= byte_count_in;
         running_xor_ff <= running_xor_in;
         check_byte_ff  <= check_byte_in;
         check_seen_ff  <= check_seen_in;
         rd_idx_ff      <= rd_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_status_ff <= err_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // payload store
   xcfr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (byte_count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_idx_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // output register is always free when ram data arrives
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOAD |-> !rsp_valid_ff)
      else $error("payload ram data arrived while output register busy");

   // drain never reads beyond the bytes stored in this frame
   a_read_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_LOAD) |-> (CW'(rd_idx_ff) < byte_count_ff))
      else $error("drain index beyond stored byte count");

   // error results are single, zero data, and marked last
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_GOOD) |-> (rsp_last_ff && rsp_data_ff == ZERO_BYTE))
      else $error("malformed error result");

   // no ram write outside of frame collection
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_IDLE && in_frame_ff && byte_count_ff < eff_len))
      else $error("payload ram written outside collection");

endmodule

// ===== sim/xcfr_frame_checker.sv =====
// xcfr_frame_checker: watches the request, result and csr ports of the xor
// checked frame receiver, predicts every result and compares it field by field.
// Depends on xcfr_pkg.
module xcfr_frame_checker
   import xcfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [STATUS_W-1:0]    rsp_tuser,
   input  logic                   rsp_tlast,
   input  logic                   csr_wr_en,
   input  logic [LEN_W-1:0]       csr_wr_data,
   output int                     mismatch_count,
   output int                     pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DATA_W-1:0]   data_byte;
      logic [IDX_W-1:0]    byte_index;
      logic [STATUS_W-1:0] status;
      logic                last;
   } frame_result_type;

   frame_result_type  expected_results[$];
   logic [LEN_W-1:0]  length_reg;
   logic              in_frame;
   logic [LEN_W-1:0]  byte_count;
   logic [DATA_W-1:0] running_xor;
   logic [DATA_W-1:0] check_byte;
   logic              check_seen;
   logic [DATA_W-1:0] payload_copy [MAX_PAYLOAD];
   int                errors = 0;
   int                shown = 0;

   // one received byte through the frame decoder
   task automatic absorb_rx_byte(input logic [DATA_W-1:0] rx);
      int unsigned      limit;
      frame_result_type r;
      limit = (length_reg == 0) ? 1 :
              (length_reg > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(length_reg);
      if (!in_frame) begin
         if (rx == HEADER_BYTE) in_frame = 1'b1;
         return;
      end
      if (rx != FOOTER_BYTE) begin
         if (byte_count < limit) begin
            payload_copy[byte_count] = rx;
            running_xor = running_xor ^ rx;
            byte_count++;
         end else begin
            // past the payload: last such byte wins as the check byte
            check_byte = rx;
            check_seen = 1'b1;
         end
         return;
      end
      if (!check_seen || byte_count == 0) begin
         r = '{data_byte: ZERO_BYTE, byte_index: '0, status: ST_SHORT, last: 1'b1};
         expected_results.push_back(r);
      end else if (running_xor != check_byte) begin
         r = '{data_byte: ZERO_BYTE, byte_index: '0, status: ST_BAD_SUM, last: 1'b1};
         expected_results.push_back(r);
      end else begin
         for (int i = 0; i < byte_count; i++) begin
            r.data_byte  = payload_copy[i];
            r.byte_index = IDX_W'(i);
            r.status     = ST_GOOD;
            r.last       = (i + 1 == byte_count);
            expected_results.push_back(r);
         end
      end
      in_frame    = 1'b0;
      byte_count  = '0;
      running_xor = '0;
      check_byte  = '0;
      check_seen  = 1'b0;
   endtask

   always @(posedge clock) begin : track
      frame_result_type got;
      frame_result_type want;
      if (reset) begin
         expected_results.delete();
         length_reg  = LEN_RESET;
         in_frame    = 1'b0;
         byte_count  = '0;
         running_xor = '0;
         check_byte  = '0;
         check_seen  = 1'b0;
      end else begin
         if (csr_wr_en) length_reg = csr_wr_data;
         if (req_tvalid && req_tready) absorb_rx_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.data_byte  = rsp_tdata[DATA_W-1:0];
            got.byte_index = rsp_tdata[DATA_W+IDX_W-1:DATA_W];
            got.status     = rsp_tuser;
            got.last       = rsp_tlast;
            if (expected_results.size() == 0) begin
               errors++;
               if (shown < 10)
                  $display("%0t frame checker: unexpected %h index %0d status %0d last %b",
                           $realtime, got.data_byte, got.byte_index, got.status,
                           got.last);
               shown++;
            end else begin
               want = expected_results.pop_front();
               if (got != want) begin
                  errors++;
                  if (shown < 10) begin
                     $display("%0t frame checker: expected %h index %0d status %0d last %b",
                              $realtime, want.data_byte, want.byte_index,
                              want.status, want.last);
                     $display("%0t frame checker: actual   %h index %0d status %0d last %b",
                              $realtime, got.data_byte, got.byte_index,
                              got.status, got.last);
                  end
                  shown++;
               end
            end
         end
      end
      mismatch_count  <= errors;
      pending_results <= expected_results.size();
   end

endmodule

// ===== sim/tb_xor_checked_frame_receiver.sv =====
// tb_xor_checked_frame_receiver: stimulus, stall patterns and verdict for the
// xor checked frame receiver; prediction lives in xcfr_frame_checker.
// Depends on xcfr_pkg, xor_checked_frame_receiver and xcfr_frame_checker.
module tb_xor_checked_frame_receiver;
   import xcfr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PAYLOAD     = 64;
   localparam int NUM_PHASES      = 10;
   localparam int PHASE_ITEMS     = 48;    // bytes per length setting, roughly
   localparam int HOLD_PHASE      = 2;     // phase where the receiver holds off
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;     // idle margin before a csr write
   localparam int TIMEOUT_NS      = 3_000_000;

   // shape of one generated frame
   typedef enum int {
      FR_GOOD,
      FR_MULTI_CHECK,
      FR_BAD_SUM,
      FR_SHORT,
      FR_NO_CHECK,
      FR_NOISE
   } frame_kind_e;

   // stall pattern of the result receiver
   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_PERIODIC
   } rx_mode_e;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata = '0;      // [7:0] rx_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;           // [7:0] data_byte, [13:8] byte_index
   logic [STATUS_W-1:0]    rsp_tuser;           // [1:0] status
   logic                   rsp_tlast;
   logic                   csr_wr_en = 1'b0;
   logic [LEN_W-1:0]       csr_wr_data = '0;

   int mismatch_count;
   int pending_results;
   int hold_cycles = 0;     // set once by stimulus, consumed by the receiver
   int burst_left = 0;      // transactions left in the current sender burst
   int phase_items = 0;

   // directed opening: footer while hunting, a good frame carrying the header
   // value and all-ones/all-zeros bytes, a checksum mismatch, a frame cut short
   // by the footer, and a full payload ended without any check byte
   logic [DATA_W-1:0] directed_bytes [0:23] = '{
      FOOTER_BYTE,
      HEADER_BYTE, 8'h00, 8'hFF, HEADER_BYTE, 8'h55, 8'h00, FOOTER_BYTE,
      HEADER_BYTE, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00, FOOTER_BYTE,
      HEADER_BYTE, 8'h11, FOOTER_BYTE,
      HEADER_BYTE, 8'h10, 8'h20, 8'h30, 8'h40, FOOTER_BYTE
   };

   // length settings per phase; the first one is the reset value, left unwritten,
   // zero and values above the payload size check the clamping
   logic [LEN_W-1:0] phase_lengths [0:NUM_PHASES-1] = '{
      LEN_RESET, 7'd1, 7'd3, 7'd64, 7'd0, 7'd127, 7'd2, 7'd5, 7'd8, 7'd100
   };

   always #6 clock = ~clock;

   xor_checked_frame_receiver #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   xcfr_frame_checker #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // random byte that is never the given value
   function automatic logic [DATA_W-1:0] rand_byte_except(input logic [DATA_W-1:0] excluded);
      logic [DATA_W-1:0] b;
      do b = DATA_W'($urandom_range(0, 255)); while (b == excluded);
      return b;
   endfunction

   // one request transaction; bursts of random length with random gaps between,
   // now and then a long burst so some stretches run without any idling
   task automatic send_byte(input logic [DATA_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      phase_items++;
   endtask

   // stop offering and wait until every predicted result has come out
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // one frame of a random kind with random content; limit is the payload
   // length the block works with under the current setting
   task automatic send_frame(input int limit);
      logic [DATA_W-1:0] body [0:MAX_PAYLOAD-1];
      logic [DATA_W-1:0] sum;
      logic [DATA_W-1:0] chk;
      frame_kind_e       kind;
      int                pick;
      int                n;
      pick = $urandom_range(0, 99);
      kind = (pick < 55) ? FR_GOOD :
             (pick < 65) ? FR_MULTI_CHECK :
             (pick < 75) ? FR_BAD_SUM :
             (pick < 85) ? FR_SHORT :
             (pick < 92) ? FR_NO_CHECK : FR_NOISE;

      // broken sequences: loose headers and footers mixed with random bytes
      if (kind == FR_NOISE) begin
         repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 3);
            send_byte(pick == 0 ? HEADER_BYTE :
                      pick == 1 ? FOOTER_BYTE : DATA_W'($urandom_range(0, 255)));
         end
         return;
      end

      // line junk ahead of the header, dropped while hunting
      if ($urandom_range(0, 6) == 0)
         repeat ($urandom_range(1, 3)) send_byte(rand_byte_except(HEADER_BYTE));

      n = (kind == FR_SHORT) ? $urandom_range(0, limit - 1) : limit;
      // a good frame needs a check byte that is not the footer value
      do begin
         sum = '0;
         for (int i = 0; i < n; i++) begin
            body[i] = rand_byte_except(FOOTER_BYTE);
            sum = sum ^ body[i];
         end
      end while (sum == FOOTER_BYTE && (kind == FR_GOOD || kind == FR_MULTI_CHECK));

      send_byte(HEADER_BYTE);
      for (int i = 0; i < n; i++) send_byte(body[i]);
      case (kind)
         FR_GOOD: begin
            send_byte(sum);
         end
         FR_MULTI_CHECK: begin
            // stale check candidates, only the last one before the footer counts
            repeat ($urandom_range(1, 3)) send_byte(rand_byte_except(FOOTER_BYTE));
            send_byte(sum);
         end
         FR_BAD_SUM: begin
            do chk = rand_byte_except(FOOTER_BYTE); while (chk == sum);
            send_byte(chk);
         end
         default: ;   // short and no-check frames end without a check byte
      endcase
      send_byte(FOOTER_BYTE);
   endtask

   // result receiver: random stall patterns in stretches, and one long hold-off
   // on request so the output fills and the footer transaction backs up
   initial begin : receiver_pattern
      rx_mode_e rx_mode;
      int       left;
      int       n;
      rx_mode = RX_OPEN;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            n = hold_cycles;
            hold_cycles <= 0;
            rsp_tready  <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            if (left == 0) begin
               rx_mode = rx_mode_e'($urandom_range(0, 3));
               left = $urandom_range(8, 80);
            end
            left--;
            case (rx_mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:   rsp_tready <= (left % 3 != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int limit;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      // sender pause: everything from the directed part must be out first
      pause_until_drained();

      // random frames under each length setting; csr writes only when idle
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) begin
            pause_until_drained();
            write_length(phase_lengths[p]);
         end
         limit = (phase_lengths[p] == 0) ? 1 :
                 (phase_lengths[p] > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(phase_lengths[p]);
         if (p == HOLD_PHASE) hold_cycles <= HOLD_OFF_CYCLES;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) send_frame(limit);
      end

      pause_until_drained();
      repeat (24) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("xor_checked_frame_receiver: match");
      else
         $display("xor_checked_frame_receiver: mismatch");
      $finish;
   end

   // watchdog against a hung handshake
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("xor_checked_frame_receiver: mismatch");
      $finish;
   end

endmodule
